>>> rtl/core/epr_pkg.sv
// Package: widths, codes and constants of the EPR pair detection counter.
`default_nettype none

package epr_pkg;

  // Random draws, angles and phases share one fixed width
  localparam int RAND_BITS = 20;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_ADDR_W-1:0] REG_ALICE_ONE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ALICE_TWO = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BOB_ONE   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_BOB_TWO   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_EMISSION  = 3'd4;

  // Ninety degrees in units of 180 / 2^RAND_BITS
  localparam logic [RAND_BITS-1:0] EMISSION_RESET = 20'd524288;

  // Analyzer setting codes
  localparam int SET_W = 2;
  localparam logic [SET_W-1:0] SET_A1B1 = 2'd0;
  localparam logic [SET_W-1:0] SET_A1B2 = 2'd1;
  localparam logic [SET_W-1:0] SET_A2B1 = 2'd2;
  localparam logic [SET_W-1:0] SET_A2B2 = 2'd3;

  // Detection class codes (o = 0, e = 1, u = undetected)
  localparam int CLS_W = 3;
  localparam logic [CLS_W-1:0] CLS_OO = 3'd0;
  localparam logic [CLS_W-1:0] CLS_OE = 3'd1;
  localparam logic [CLS_W-1:0] CLS_EO = 3'd2;
  localparam logic [CLS_W-1:0] CLS_EE = 3'd3;
  localparam logic [CLS_W-1:0] CLS_UO = 3'd4;
  localparam logic [CLS_W-1:0] CLS_UE = 3'd5;
  localparam logic [CLS_W-1:0] CLS_OU = 3'd6;
  localparam logic [CLS_W-1:0] CLS_EU = 3'd7;

  // Class counters
  localparam int NUM_CNT = 32;
  localparam int CNT_IDX_W = SET_W + CLS_W;
  localparam int CNT_W = 21;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Running J: raw sum and clamped output
  localparam int J_W = 24;
  localparam int JRAW_W = 25;
  localparam logic signed [JRAW_W-1:0] J_MAX = 25'sd8388607;
  localparam logic signed [JRAW_W-1:0] J_MIN = -25'sd8388608;

  // Divide by three: floor(s * ceil(2^24 / 3) / 2^24), exact for s < 2^23
  localparam int MIX_SUM_W = RAND_BITS + 2;
  localparam int MIX_RECIP_W = 23;
  localparam logic [MIX_RECIP_W-1:0] MIX_RECIP = 23'd5592406;
  localparam int MIX_SHIFT = 24;
  localparam int MIX_PROD_W = MIX_SUM_W + MIX_RECIP_W;

  // Class stage payload
  typedef struct packed {
    logic [SET_W-1:0] setting;
    logic [CLS_W-1:0] cls;
  } cls_beat_t;

endpackage

`default_nettype wire

>>> rtl/core/epr_pair_detect_counter_top.sv
// Top level: EPR pair detection counter with per-setting class counts and running J.
`default_nettype none

// One beat in, one beat out. The block takes a beat every cycle unless the
// result stream stalls, and presents its result through three registers: an
// input register, a class register after the polarizer logic, and the result
// register, where the 32 saturating class counters and the running J are
// updated in the same cycle. The divide by three of the Malus mix is a
// constant multiply in the class stage logic. J is tracked as an unclamped
// sum that moves by one per counted beat in one of its classes and is
// clamped to the signed 24-bit range on the way out. Counters and J clear
// on reset. Configuration writes take effect at once and are meant to be
// issued while no beat is in flight; out-of-range indexes are ignored.
module epr_pair_detect_counter_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input stream
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [19:0] rand_phase, [39:20] rand_mix_one, [59:40] rand_mix_two, [79:60] rand_coin
  input  wire logic [79:0]                    in_tdata,
  // [1:0] setting
  input  wire logic [epr_pkg::SET_W-1:0]      in_tuser,
  // Result stream
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [23:0] j_value (signed)
  output logic [epr_pkg::J_W-1:0]             out_tdata,
  // [2:0] detect_class
  output logic [epr_pkg::CLS_W-1:0]           out_tuser,
  // Configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [epr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [epr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int RB = epr_pkg::RAND_BITS;

  localparam logic [RB:0] HALF    = (RB+1)'(1) << (RB - 1);
  localparam logic [RB:0] QUARTER = (RB+1)'(1) << (RB - 2);

  // Polarizer rule: returns {state, outcome}
  function automatic logic [1:0] pass_pol(input logic [RB-1:0] phase,
                                          input logic [RB-1:0] mix,
                                          input logic [RB-1:0] pol);
    logic [RB-1:0] a;
    logic [RB+1:0] b;
    logic [RB:0]   c;
    logic          o;
    a = phase - pol;
    b = {1'b0, a, 1'b0} + {2'b00, mix};
    if (!a[RB-1]) begin
      if (b[RB+1:RB] == 2'b00) begin
        c = {1'b0, a};
        o = 1'b0;
      end else begin
        c = HALF - {1'b0, a};
        o = 1'b1;
      end
    end else begin
      if (!b[RB+1]) begin
        c = {1'b0, a} - HALF;
        o = 1'b1;
      end else begin
        c = (HALF << 1) - {1'b0, a};
        o = 1'b0;
      end
    end
    return {(c >= QUARTER), o};
  endfunction

  // ---------------- configuration registers
  logic [RB-1:0] alice_one_r, alice_two_r, bob_one_r, bob_two_r, emission_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alice_one_r <= '0;
      alice_two_r <= '0;
      bob_one_r   <= '0;
      bob_two_r   <= '0;
      emission_r  <= epr_pkg::EMISSION_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        epr_pkg::REG_ALICE_ONE: alice_one_r <= cfg_wdata;
        epr_pkg::REG_ALICE_TWO: alice_two_r <= cfg_wdata;
        epr_pkg::REG_BOB_ONE:   bob_one_r   <= cfg_wdata;
        epr_pkg::REG_BOB_TWO:   bob_two_r   <= cfg_wdata;
        epr_pkg::REG_EMISSION:  emission_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline flow control
  logic in_v_r, cls_v_r, out_v_r;
  logic adv_out, adv_cls, adv_in;

  assign adv_out   = !out_v_r || out_tready;
  assign adv_cls   = !cls_v_r || adv_out;
  assign adv_in    = !in_v_r || adv_cls;
  assign in_tready = adv_in;

  // ---------------- stage 1: input register
  logic [epr_pkg::SET_W-1:0] set_r;
  logic [RB-1:0] phase_r, mix_one_r, mix_two_r, coin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (adv_in) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in && in_tvalid) begin
      set_r     <= in_tuser;
      phase_r   <= in_tdata[19:0];
      mix_one_r <= in_tdata[39:20];
      mix_two_r <= in_tdata[59:40];
      coin_r    <= in_tdata[79:60];
    end
  end

  // ---------------- stage 2 logic: mix, polarizers, class
  logic [epr_pkg::MIX_SUM_W-1:0]  mix_sum;
  logic [epr_pkg::MIX_PROD_W-1:0] mix_prod;
  logic [RB-1:0]                  mix, bob_phase, apol, bpol;
  logic [1:0]                     ra, rb;
  epr_pkg::cls_beat_t             cls_nxt;

  always_comb begin
    mix_sum   = {2'b00, mix_one_r} + {1'b0, mix_two_r, 1'b0};
    mix_prod  = epr_pkg::MIX_PROD_W'(mix_sum) * epr_pkg::MIX_PROD_W'(epr_pkg::MIX_RECIP);
    mix       = mix_prod[epr_pkg::MIX_SHIFT +: RB];
    bob_phase = phase_r + emission_r;
    apol      = set_r[1] ? alice_two_r : alice_one_r;
    bpol      = set_r[0] ? bob_two_r : bob_one_r;
    ra        = pass_pol(phase_r, mix, apol);
    rb        = pass_pol(bob_phase, mix, bpol);

    cls_nxt.setting = set_r;
    if (ra[1] ^ rb[1]) begin
      // single detection: coin below half leaves Alice undetected
      if (!coin_r[RB-1]) begin
        cls_nxt.cls = epr_pkg::CLS_UO | {2'b00, rb[0]};
      end else begin
        cls_nxt.cls = epr_pkg::CLS_OU | {2'b00, ra[0]};
      end
    end else begin
      cls_nxt.cls = {1'b0, ra[0], rb[0]};
    end
  end

  // ---------------- stage 2: class register
  epr_pkg::cls_beat_t cls_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_v_r <= 1'b0;
    end else if (adv_cls) begin
      cls_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_cls && in_v_r) begin
      cls_r <= cls_nxt;
    end
  end

  // ---------------- stage 3 logic: counter update and J step
  logic [epr_pkg::CNT_W-1:0]        cnt_r [epr_pkg::NUM_CNT];
  logic [epr_pkg::CNT_IDX_W-1:0]    cnt_idx;
  logic                             cnt_upd, cnt_sat, j_hit, j_neg;
  logic signed [epr_pkg::JRAW_W-1:0] jraw_r, jraw_nxt;
  logic [epr_pkg::J_W-1:0]          j_clamp;

  assign cnt_idx = {cls_r.setting, cls_r.cls};
  assign cnt_upd = adv_out && cls_v_r;
  assign cnt_sat = (cnt_r[cnt_idx] == epr_pkg::CNT_MAX);

  // which counters J adds or subtracts
  always_comb begin
    j_hit = 1'b0;
    j_neg = 1'b0;
    case (cls_r.setting)
      epr_pkg::SET_A1B1: begin
        j_hit = (cls_r.cls == epr_pkg::CLS_OO);
        j_neg = 1'b1;
      end
      epr_pkg::SET_A1B2: j_hit = (cls_r.cls == epr_pkg::CLS_OE) ||
                                 (cls_r.cls == epr_pkg::CLS_OU);
      epr_pkg::SET_A2B1: j_hit = (cls_r.cls == epr_pkg::CLS_EO) ||
                                 (cls_r.cls == epr_pkg::CLS_UO);
      epr_pkg::SET_A2B2: j_hit = (cls_r.cls == epr_pkg::CLS_OO);
      default: ;
    endcase
  end

  always_comb begin
    jraw_nxt = jraw_r;
    if (cnt_upd && !cnt_sat && j_hit) begin
      jraw_nxt = j_neg ? (jraw_r - 25'sd1) : (jraw_r + 25'sd1);
    end
    if (jraw_nxt > epr_pkg::J_MAX) begin
      j_clamp = epr_pkg::J_MAX[epr_pkg::J_W-1:0];
    end else if (jraw_nxt < epr_pkg::J_MIN) begin
      j_clamp = epr_pkg::J_MIN[epr_pkg::J_W-1:0];
    end else begin
      j_clamp = jraw_nxt[epr_pkg::J_W-1:0];
    end
  end

  // ---------------- stage 3: counters, J and result register
  logic [epr_pkg::CLS_W-1:0] out_cls_r;
  logic [epr_pkg::J_W-1:0]   out_j_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      jraw_r  <= '0;
      for (int i = 0; i < epr_pkg::NUM_CNT; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (adv_out) begin
        out_v_r <= cls_v_r;
      end
      if (cnt_upd && !cnt_sat) begin
        cnt_r[cnt_idx] <= cnt_r[cnt_idx] + 1'b1;
      end
      jraw_r <= jraw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_upd) begin
      out_cls_r <= cls_r.cls;
      out_j_r   <= j_clamp;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_cls_r;
  assign out_tdata  = out_j_r;

  // ---------------- assertions
  // a counted beat bumps its counter by one unless saturated
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_upd |=> (cnt_r[$past(cnt_idx)] == $past(cnt_r[cnt_idx]) + 1'b1) ||
                ($past(cnt_r[cnt_idx]) == epr_pkg::CNT_MAX))
    else $error("class counter step wrong");

  // J moves only when a beat is counted
  a_j_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !cnt_upd |=> $stable(jraw_r))
    else $error("running J moved without a counted beat");

  // shown J agrees with the raw sum when in range
  a_j_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (jraw_r <= epr_pkg::J_MAX) && (jraw_r >= epr_pkg::J_MIN)
      |-> out_j_r == jraw_r[epr_pkg::J_W-1:0])
    else $error("result J differs from running sum");

  // a result appears only from a filled class stage
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !$past(out_v_r) |-> $past(cls_v_r))
    else $error("result beat from empty pipeline");

endmodule

`default_nettype wire
